// File: rtl/lpht_pkg.sv
`default_nettype none
package lpht_pkg;
   localparam int SlotBits  = 10;
   localparam int TableSlots = 1 << SlotBits;
   localparam int KeyBits   = 32;
   localparam int CountBits = SlotBits + 1;

   typedef logic [SlotBits-1:0]  slot_type;
   typedef logic [KeyBits-1:0]   key_type;
   typedef logic [CountBits-1:0] count_type;

   typedef enum logic [1:0] {
      OP_FIND   = 2'd0,
      OP_INSERT = 2'd1,
      OP_DELETE = 2'd2,
      OP_SPARE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_DUPLICATE = 2'd1,
      ST_FULL      = 2'd2,
      ST_ABSENT    = 2'd3
   } status_type;

   // command passed from the front end to the probe engine
   typedef struct packed {
      op_type  op;
      key_type key;
   } cmd_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_PROBE_RD,
      S_PROBE_CHK,
      S_SHIFT_RD,
      S_SHIFT_CHK,
      S_DONE
   } eng_state_type;

   // true when a < b <= c, cyclically
   function automatic logic in_cyclic(slot_type a, slot_type b, slot_type c);
      return ((a < b) && (b <= c)) || ((a < b) && (c < a)) || ((b <= c) && (c < a));
   endfunction
endpackage
`default_nettype wire

// File: rtl/linear_probe_hash_table.sv
// Each operation probes 1..1024 slots, each with a RAM read state and a check state;
// a delete that hits then runs a backward shift, reading and checking slot by slot.
// The engine takes a new operation only once the current one has finished; a
// two-entry queue and a result register let each side stall on its own.
// Reset (synchronous) empties the queue and count, then a pass over all 1024 slots
// clears the occupied flags in key RAM; requests wait in the queue until it is done.
`default_nettype none
module linear_probe_hash_table
   import lpht_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire [31:0]  req_tdata,   // [31:0] key
   input  wire [1:0]   req_tuser,   // [1:0] req_type
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [31:0] rsp_tdata    // [9:0] slot_index, [10] found, [12:11] status,
                                    // [23:13] entry_count, [31:24] zero
);
   cmd_type    in_cmd, q_cmd;
   logic       q_valid, q_ready, found;
   slot_type   slot;
   status_type status;
   count_type  count;

   assign in_cmd.op  = op_type'(req_tuser);
   assign in_cmd.key = req_tdata;

   lpht_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready), .in_cmd(in_cmd),
      .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
   );

   lpht_engine u_engine (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_slot(slot), .out_found(found), .out_status(status), .out_count(count)
   );

   assign rsp_tdata = {8'd0, count, status, found, slot};
endmodule
`default_nettype wire

// File: rtl/lpht_ram.sv
`default_nettype none
module lpht_ram #(
   parameter int Width = 32,
   parameter int Depth = 1024
) (
   input  wire                     clock,
   input  wire                     wr_en,
   input  wire [$clog2(Depth)-1:0] wr_addr,
   input  wire [Width-1:0]         wr_data,
   input  wire [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]        rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// File: rtl/lpht_front.sv
`default_nettype none
module lpht_front
   import lpht_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         in_valid,
   output logic        in_ready,
   input  wire cmd_type in_cmd,
   output logic        q_valid,
   input  wire         q_ready,
   output cmd_type     q_cmd
);
   // two-entry queue; unused request codes fold to find here
   cmd_type    buf_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, rd_in, wr_ff, wr_in;
   logic       push, pop;
   cmd_type    cls;

   always_comb begin
      cls = in_cmd;
      if (in_cmd.op == OP_SPARE) begin
         cls.op = OP_FIND;
      end
   end

   assign in_ready = (cnt_ff != 2'd2);
   assign q_valid  = (cnt_ff != 2'd0);
   assign q_cmd    = buf_ff[rd_ff];
   assign push     = in_valid && in_ready;
   assign pop      = q_valid && q_ready;

   always_comb begin
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
      rd_in  = rd_ff ^ pop;
      wr_in  = wr_ff ^ push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
      end
      if (push) begin
         buf_ff[wr_ff] <= cls;
      end
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("queue count out of range");
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0) |-> (rd_ff == wr_ff))
      else $error("empty queue with pointer skew");
   assert property (@(posedge clock) disable iff (reset)
      q_valid |-> (q_cmd.op != OP_SPARE))
      else $error("unclassified op in queue");
endmodule
`default_nettype wire

// File: rtl/lpht_engine.sv
`default_nettype none
module lpht_engine
   import lpht_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         q_valid,
   output logic        q_ready,
   input  wire cmd_type q_cmd,
   output logic        out_valid,
   input  wire         out_ready,
   output slot_type    out_slot,
   output logic        out_found,
   output status_type  out_status,
   output count_type   out_count
);
   eng_state_type state_ff, state_in;
   cmd_type       cmd_ff, cmd_in;
   slot_type      pos_ff, pos_in, hole_ff, hole_in;
   count_type     steps_ff, steps_in, count_ff, count_in;

   logic       rv_ff, rv_in;
   slot_type   rslot_ff, rslot_in;
   logic       rfound_ff, rfound_in;
   status_type rstat_ff, rstat_in;

   // result register toward the output, loaded when an operation finishes
   slot_type   oslot_ff;
   logic       ofound_ff;
   status_type ostat_ff;
   count_type  ocount_ff;
   logic       out_load;

   // key RAM word: occupied flag above the key
   logic             wr_en;
   slot_type         wr_addr, rd_addr;
   logic [KeyBits:0] wr_data, rd_data;
   logic             rd_occ, shift_occ;
   key_type          rd_key;
   slot_type         home, cand_home;

   lpht_ram #(.Width(KeyBits + 1), .Depth(TableSlots)) u_keys (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   assign rd_occ    = rd_data[KeyBits];
   assign rd_key    = rd_data[KeyBits-1:0];
   // the hole is written empty only when the shift ends
   assign shift_occ = rd_occ && (pos_ff != hole_ff);
   assign home      = cmd_ff.key[SlotBits-1:0];
   assign cand_home = rd_key[SlotBits-1:0];
   assign rd_addr   = pos_ff;
   assign out_valid = rv_ff;
   assign out_slot  = oslot_ff;
   assign out_found = ofound_ff;
   assign out_status = ostat_ff;
   assign out_count = ocount_ff;

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      pos_in = pos_ff;
      hole_in = hole_ff;
      steps_in = steps_ff;
      count_in = count_ff;
      rv_in = rv_ff && !out_ready;
      rslot_in = rslot_ff;
      rfound_in = rfound_ff;
      rstat_in = rstat_ff;
      out_load = 1'b0;
      q_ready = 1'b0;
      wr_en = 1'b0;
      wr_addr = hole_ff;
      wr_data = {1'b1, rd_key};
      unique case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1;
            wr_addr = pos_ff;
            wr_data = '0;
            pos_in = pos_ff + 1'b1;
            if (pos_ff == slot_type'(TableSlots - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            q_ready = 1'b1;
            if (q_valid) begin
               cmd_in   = q_cmd;
               pos_in   = q_cmd.key[SlotBits-1:0];
               steps_in = '0;
               state_in = S_PROBE_RD;
            end
         end
         S_PROBE_RD: state_in = S_PROBE_CHK;
         S_PROBE_CHK: begin
            rslot_in  = pos_ff;
            rfound_in = 1'b0;
            if (!rd_occ) begin
               if (cmd_ff.op == OP_INSERT) begin
                  wr_en = 1'b1;
                  wr_addr = pos_ff;
                  wr_data = {1'b1, cmd_ff.key};
                  count_in = count_ff + 1'b1;
                  rstat_in = ST_OK;
               end else begin
                  rstat_in = ST_ABSENT;
               end
               state_in = S_DONE;
            end else if (rd_key == cmd_ff.key) begin
               rfound_in = 1'b1;
               if (cmd_ff.op == OP_INSERT) begin
                  rstat_in = ST_DUPLICATE;
                  state_in = S_DONE;
               end else if (cmd_ff.op == OP_DELETE) begin
                  rstat_in = ST_OK;
                  count_in = count_ff - 1'b1;
                  hole_in = pos_ff;
                  pos_in = pos_ff + 1'b1;
                  steps_in = '0;
                  state_in = S_SHIFT_RD;
               end else begin
                  rstat_in = ST_OK;
                  state_in = S_DONE;
               end
            end else if (steps_ff == count_type'(TableSlots - 1)) begin
               rslot_in = home;
               rstat_in = (cmd_ff.op == OP_INSERT) ? ST_FULL : ST_ABSENT;
               state_in = S_DONE;
            end else begin
               pos_in = pos_ff + 1'b1;
               steps_in = steps_ff + 1'b1;
               state_in = S_PROBE_RD;
            end
         end
         S_SHIFT_RD: state_in = S_SHIFT_CHK;
         S_SHIFT_CHK: begin
            if (!shift_occ || steps_ff == count_type'(TableSlots)) begin
               wr_en = 1'b1;
               wr_addr = hole_ff;
               wr_data = '0;
               state_in = S_DONE;
            end else begin
               if (!in_cyclic(hole_ff, cand_home, pos_ff)) begin
                  wr_en = 1'b1;
                  wr_addr = hole_ff;
                  hole_in = pos_ff;
               end
               pos_in = pos_ff + 1'b1;
               steps_in = steps_ff + 1'b1;
               state_in = S_SHIFT_RD;
            end
         end
         S_DONE: begin
            if (!rv_ff || out_ready) begin
               rv_in = 1'b1;
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         pos_ff   <= '0;
         count_ff <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         count_ff <= count_in;
         rv_ff    <= rv_in;
      end
      cmd_ff    <= cmd_in;
      hole_ff   <= hole_in;
      steps_ff  <= steps_in;
      rslot_ff  <= rslot_in;
      rfound_ff <= rfound_in;
      rstat_ff  <= rstat_in;
      if (out_load) begin
         oslot_ff  <= rslot_ff;
         ofound_ff <= rfound_ff;
         ostat_ff  <= rstat_ff;
         ocount_ff <= count_ff;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= count_type'(TableSlots))
      else $error("entry count overflow");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PROBE_CHK && rd_occ && rd_key == cmd_ff.key
       && cmd_ff.op == OP_DELETE) |=> (state_ff == S_SHIFT_RD))
      else $error("delete hit did not start backward shift");
   assert property (@(posedge clock) disable iff (reset)
      (rv_ff && !out_ready) |=> (rv_ff && $stable(oslot_ff) && $stable(ostat_ff)
       && $stable(ocount_ff)))
      else $error("result lost while stalled");
   assert property (@(posedge clock) disable iff (reset)
      (rv_ff && ofound_ff) |-> (ostat_ff == ST_OK || ostat_ff == ST_DUPLICATE))
      else $error("found with inconsistent status");
endmodule
`default_nettype wire
